FILE: rtl/tlbh_pkg.sv
// tlbh_pkg: shared types and constants of the traffic log bar history block
`default_nettype none

package tlbh_pkg;

    // field widths
    localparam int COUNT_W  = 64;
    localparam int HEIGHT_W = 8;
    localparam int LEN_W    = 7;
    localparam int PROD_W   = HEIGHT_W + COUNT_W;
    localparam int COL_W    = 6;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 32;

    // bit length rules of the bar
    localparam logic [LEN_W-1:0] MIN_LEN    = 7'd8;
    localparam logic [LEN_W-1:0] LEN_OFFSET = 7'd7;
    localparam logic [LEN_W-1:0] CARRY_LEN  = 7'd65;

    // action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // results of the serial delta unit
    typedef struct packed {
        logic [COUNT_W-1:0]  dtx;
        logic [COUNT_W:0]    total;
        logic [HEIGHT_W-1:0] bar;
        logic                rx_gt_tx;
    } delta_res_t;

    // one stored history column
    typedef struct packed {
        logic [HEIGHT_W-1:0] tx;
        logic [HEIGHT_W-1:0] rx;
    } hist_word_t;

    // one result item, total height in the lowest bits
    typedef struct packed {
        logic                first_sample;
        logic [HEIGHT_W-1:0] rx_height;
        logic [HEIGHT_W-1:0] tx_height;
        logic [HEIGHT_W-1:0] total_height;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/traffic_log_bar_history.sv
// traffic_log_bar_history: top level with item sequencer, slot state and output register
//
// Input items arrive on s_tvalid/s_tready/s_tdata and each gives exactly one result
// item on m_tvalid/m_tready/m_tdata. The block works on one item at a time.
// A sample item runs a bit-serial delta unit over the 64 counter bits,
// then 8 shift-add steps for bar*tx and 8 restoring division steps for the transmit
// share; the product and division are skipped when the bar is 0 or 1.
// A read item reduces the column by repeated subtraction of the ring length (up to
// 63/HISTORY_LEN steps), then reads the column memory in ST_RADDR and ST_RDATA.
// A clear item, an unused action and a slot not below SLOTS give a zero result.
// s_tready rises with the result, so the next item can be accepted while the result
// is still shown. History entries sit in a plain memory; a per-slot write position
// and wrap flag mark which entries hold data, the rest read as zero, so no clearing
// pass is needed after reset or clear.
// Reset empties every slot and sets max_bar_height to 23. The result waits in an
// output register, so a stalled receiver does not stop the next item from being
// accepted; the block only holds s_tready low once that next result is ready too.
// The user writes max_bar_height (cfg_wr_en/cfg_wr_data) only while the block is idle; the block does not enforce it.
`default_nettype none

module traffic_log_bar_history #(
    parameter int SLOTS       = 4,
    parameter int HISTORY_LEN = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [7:0]                    cfg_wr_data,  // max_bar_height
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // action[1:0], slot[3:2], rx_count[67:4], tx_count[131:68], column[137:132]
    input  wire logic [tlbh_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // total_height[7:0], tx_height[15:8], rx_height[23:16], first_sample[24]
    output logic [tlbh_pkg::OUT_W-1:0]         m_tdata
);

    localparam int KW = $clog2(HISTORY_LEN);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = SW + KW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DELTA, ST_SHARE, ST_MOD, ST_RADDR, ST_RDATA, ST_OUT
    } state_t;

    state_t                             state_reg;
    logic [7:0]                         max_height_reg;
    logic [SW-1:0]                      slot_reg;
    logic                               first_reg;
    logic [tlbh_pkg::COL_W-1:0]         colr_reg;
    logic [KW-1:0]                      k_reg;
    logic                               hit_reg;
    tlbh_pkg::out_item_t                res_reg;
    tlbh_pkg::out_item_t                out_reg;
    logic                               out_valid_reg;
    logic                               in_use_reg [SLOTS];
    logic                               wrap_reg   [SLOTS];
    logic [KW-1:0]                      wp_reg     [SLOTS];
    logic [tlbh_pkg::COUNT_W-1:0]       last_rx_reg [SLOTS];
    logic [tlbh_pkg::COUNT_W-1:0]       last_tx_reg [SLOTS];

    logic [1:0]                         in_action;
    logic [1:0]                         in_slot;
    logic [tlbh_pkg::COUNT_W-1:0]       in_rx;
    logic [tlbh_pkg::COUNT_W-1:0]       in_tx;
    logic [tlbh_pkg::COL_W-1:0]         in_column;
    logic                               in_accept;
    logic                               slot_ok;
    logic [SW-1:0]                      in_idx;
    logic                               delta_start;
    logic                               delta_done;
    tlbh_pkg::delta_res_t               delta_res;
    logic                               share_start;
    logic                               share_done;
    logic [tlbh_pkg::HEIGHT_W-1:0]      share_q;
    logic                               mem_wr_en;
    tlbh_pkg::hist_word_t               mem_wr_data;
    tlbh_pkg::hist_word_t               mem_rd_data;
    logic                               col_ge;
    logic [8:0]                         ksum;
    logic [8:0]                         kwrap;
    logic [KW-1:0]                      k_next;
    logic                               hit_next;
    logic                               out_free;

    // input item fields
    assign in_action = s_tdata[1:0];
    assign in_slot   = s_tdata[3:2];
    assign in_rx     = s_tdata[67:4];
    assign in_tx     = s_tdata[131:68];
    assign in_column = s_tdata[137:132];

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign slot_ok     = ({3'b0, in_slot} < 5'(SLOTS));
    assign in_idx      = SW'(in_slot);
    assign delta_start = in_accept && slot_ok && (in_action == tlbh_pkg::ACT_SAMPLE);
    assign share_start = (state_reg == ST_DELTA) && delta_done;
    assign out_free    = !out_valid_reg || m_tready;

    // column reduction and ring position of a read
    always_comb
    begin
        col_ge   = (9'(colr_reg) >= 9'(HISTORY_LEN));
        ksum     = 9'(wp_reg[slot_reg]) + 9'(colr_reg);
        kwrap    = (ksum >= 9'(HISTORY_LEN)) ? (ksum - 9'(HISTORY_LEN)) : ksum;
        k_next   = KW'(kwrap);
        hit_next = wrap_reg[slot_reg] || (k_next < wp_reg[slot_reg]);
    end

    // column write at the end of a sample
    assign mem_wr_en      = (state_reg == ST_SHARE) && share_done;
    assign mem_wr_data.tx = share_q;
    assign mem_wr_data.rx = delta_res.bar - share_q;

    tlbh_delta u_delta (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (delta_start),
        .first      (!in_use_reg[in_idx]),
        .rx_new     (in_rx),
        .tx_new     (in_tx),
        .rx_old     (last_rx_reg[in_idx]),
        .tx_old     (last_tx_reg[in_idx]),
        .max_height (max_height_reg),
        .done       (delta_done),
        .res        (delta_res)
    );

    tlbh_share u_share (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (share_start),
        .res      (delta_res),
        .done     (share_done),
        .tx_share (share_q)
    );

    tlbh_hist #(
        .AW (AW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr ({slot_reg, wp_reg[slot_reg]}),
        .wr_data (mem_wr_data),
        .rd_addr ({slot_reg, k_reg}),
        .rd_data (mem_rd_data)
    );

    // last counters of each slot
    always_ff @(posedge clk)
    begin
        if (delta_start)
        begin
            last_rx_reg[in_idx] <= in_rx;
            last_tx_reg[in_idx] <= in_tx;
        end
    end

    // item sequencer, slot state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_height_reg <= 8'd23;
            slot_reg       <= '0;
            first_reg      <= 1'b0;
            colr_reg       <= '0;
            k_reg          <= '0;
            hit_reg        <= 1'b0;
            res_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                in_use_reg[i] <= 1'b0;
                wrap_reg[i]   <= 1'b0;
                wp_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_height_reg <= cfg_wr_data;
            end

            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        slot_reg  <= in_idx;
                        colr_reg  <= in_column;
                        first_reg <= !in_use_reg[in_idx];
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                        if (slot_ok)
                        begin
                            unique case (in_action)
                                tlbh_pkg::ACT_SAMPLE:
                                begin
                                    in_use_reg[in_idx] <= 1'b1;
                                    state_reg          <= ST_DELTA;
                                end
                                tlbh_pkg::ACT_READ:
                                begin
                                    state_reg <= ST_MOD;
                                end
                                tlbh_pkg::ACT_CLEAR:
                                begin
                                    in_use_reg[in_idx] <= 1'b0;
                                    wrap_reg[in_idx]   <= 1'b0;
                                    wp_reg[in_idx]     <= '0;
                                end
                                default:
                                begin
                                    state_reg <= ST_OUT;
                                end
                            endcase
                        end
                    end
                end
                ST_DELTA:
                begin
                    if (delta_done)
                    begin
                        state_reg <= ST_SHARE;
                    end
                end
                ST_SHARE:
                begin
                    if (share_done)
                    begin
                        res_reg.total_height <= delta_res.bar;
                        res_reg.tx_height    <= share_q;
                        res_reg.rx_height    <= delta_res.bar - share_q;
                        res_reg.first_sample <= first_reg;
                        // advance the ring position
                        if (wp_reg[slot_reg] == KW'(HISTORY_LEN - 1))
                        begin
                            wp_reg[slot_reg]   <= '0;
                            wrap_reg[slot_reg] <= 1'b1;
                        end
                        else
                        begin
                            wp_reg[slot_reg] <= wp_reg[slot_reg] + KW'(1);
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_MOD:
                begin
                    if (col_ge)
                    begin
                        colr_reg <= 6'(9'(colr_reg) - 9'(HISTORY_LEN));
                    end
                    else
                    begin
                        k_reg     <= k_next;
                        hit_reg   <= hit_next;
                        state_reg <= ST_RADDR;
                    end
                end
                ST_RADDR:
                begin
                    state_reg <= ST_RDATA;
                end
                ST_RDATA:
                begin
                    // entries never written since the last clear read as zero
                    if (hit_reg)
                    begin
                        res_reg.total_height <= mem_rd_data.tx + mem_rd_data.rx;
                        res_reg.tx_height    <= mem_rd_data.tx;
                        res_reg.rx_height    <= mem_rd_data.rx;
                    end
                    res_reg.first_sample <= 1'b0;
                    state_reg            <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg};

endmodule

`default_nettype wire

FILE: rtl/tlbh_delta.sv
// tlbh_delta: bit-serial counter deltas, delta sum, bit length and bar height
`default_nettype none

module tlbh_delta (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               first,
    input  wire logic [tlbh_pkg::COUNT_W-1:0]       rx_new,
    input  wire logic [tlbh_pkg::COUNT_W-1:0]       tx_new,
    input  wire logic [tlbh_pkg::COUNT_W-1:0]       rx_old,
    input  wire logic [tlbh_pkg::COUNT_W-1:0]       tx_old,
    input  wire logic [tlbh_pkg::HEIGHT_W-1:0]      max_height,
    output logic                                    done,
    output tlbh_pkg::delta_res_t                    res
);

    logic [tlbh_pkg::COUNT_W-1:0] a_rx_reg;
    logic [tlbh_pkg::COUNT_W-1:0] b_rx_reg;
    logic [tlbh_pkg::COUNT_W-1:0] a_tx_reg;
    logic [tlbh_pkg::COUNT_W-1:0] b_tx_reg;
    logic [tlbh_pkg::COUNT_W-1:0] dtx_reg;
    logic [tlbh_pkg::COUNT_W-1:0] sum_reg;
    logic                         brx_reg;
    logic                         btx_reg;
    logic                         carry_reg;
    logic                         gt_reg;
    logic [tlbh_pkg::LEN_W-1:0]   len_reg;
    logic [5:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic drx_bit;
    logic dtx_bit;
    logic brx_next;
    logic btx_next;
    logic sum_bit;
    logic carry_next;
    logic gt_next;
    logic [tlbh_pkg::LEN_W-1:0]    len_full;
    logic [tlbh_pkg::LEN_W-1:0]    len_excess;
    logic [tlbh_pkg::HEIGHT_W-1:0] bar;

    // one bit of each subtraction, the sum and the compare per cycle
    always_comb
    begin
        drx_bit    = a_rx_reg[0] ^ b_rx_reg[0] ^ brx_reg;
        brx_next   = (~a_rx_reg[0] & b_rx_reg[0]) | (~(a_rx_reg[0] ^ b_rx_reg[0]) & brx_reg);
        dtx_bit    = a_tx_reg[0] ^ b_tx_reg[0] ^ btx_reg;
        btx_next   = (~a_tx_reg[0] & b_tx_reg[0]) | (~(a_tx_reg[0] ^ b_tx_reg[0]) & btx_reg);
        sum_bit    = drx_bit ^ dtx_bit ^ carry_reg;
        carry_next = (drx_bit & dtx_bit) | (carry_reg & (drx_bit ^ dtx_bit));
        gt_next    = (drx_bit & ~dtx_bit) | (~(drx_bit ^ dtx_bit) & gt_reg);
    end

    // bar height from the bit length of the sum
    always_comb
    begin
        len_full   = carry_reg ? tlbh_pkg::CARRY_LEN : len_reg;
        len_excess = len_full - tlbh_pkg::LEN_OFFSET;
        if (len_full == '0)
        begin
            bar = '0;
        end
        else if (len_full < tlbh_pkg::MIN_LEN)
        begin
            bar = 8'd1;
        end
        else if ({1'b0, len_excess} >= max_height)
        begin
            bar = max_height;
        end
        else
        begin
            bar = {1'b0, len_excess};
        end
    end

    // sequencing of the 64 bit steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and result shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_rx_reg  <= first ? '0 : rx_new;
            b_rx_reg  <= first ? '0 : rx_old;
            a_tx_reg  <= first ? '0 : tx_new;
            b_tx_reg  <= first ? '0 : tx_old;
            brx_reg   <= 1'b0;
            btx_reg   <= 1'b0;
            carry_reg <= 1'b0;
            gt_reg    <= 1'b0;
            len_reg   <= '0;
        end
        else if (busy_reg)
        begin
            a_rx_reg  <= a_rx_reg >> 1;
            b_rx_reg  <= b_rx_reg >> 1;
            a_tx_reg  <= a_tx_reg >> 1;
            b_tx_reg  <= b_tx_reg >> 1;
            brx_reg   <= brx_next;
            btx_reg   <= btx_next;
            carry_reg <= carry_next;
            gt_reg    <= gt_next;
            dtx_reg   <= {dtx_bit, dtx_reg[tlbh_pkg::COUNT_W-1:1]};
            sum_reg   <= {sum_bit, sum_reg[tlbh_pkg::COUNT_W-1:1]};
            if (sum_bit)
            begin
                len_reg <= 7'(cnt_reg) + 7'd1;
            end
        end
    end

    assign done         = done_reg;
    assign res.dtx      = dtx_reg;
    assign res.total    = {carry_reg, sum_reg};
    assign res.bar      = bar;
    assign res.rx_gt_tx = gt_reg;

endmodule

`default_nettype wire

FILE: rtl/tlbh_share.sv
// tlbh_share: transmit share of a bar, shift-add product then restoring division
`default_nettype none

module tlbh_share (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire tlbh_pkg::delta_res_t          res,
    output logic                               done,
    output logic [tlbh_pkg::HEIGHT_W-1:0]      tx_share
);

    typedef enum logic [1:0] {SH_IDLE, SH_MUL, SH_DIV} state_t;

    state_t                          state_reg;
    logic [2:0]                      cnt_reg;
    logic                            done_reg;
    logic [tlbh_pkg::HEIGHT_W-1:0]   q_reg;
    logic [tlbh_pkg::HEIGHT_W-1:0]   bar_sh_reg;
    logic [tlbh_pkg::PROD_W-1:0]     num_reg;
    logic [tlbh_pkg::PROD_W-1:0]     den_reg;

    logic [tlbh_pkg::PROD_W:0]       diff;
    logic                            num_ge;
    logic [tlbh_pkg::PROD_W-1:0]     addend;

    // one product step and one quotient trial
    always_comb
    begin
        addend = bar_sh_reg[tlbh_pkg::HEIGHT_W-1] ? tlbh_pkg::PROD_W'(res.dtx) : '0;
        diff   = {1'b0, num_reg} - {1'b0, den_reg};
        num_ge = !diff[tlbh_pkg::PROD_W];
    end

    // control and quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            q_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SH_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg <= '0;
                        if (res.bar == '0 || res.total == '0)
                        begin
                            q_reg    <= '0;
                            done_reg <= 1'b1;
                        end
                        else if (res.bar == 8'd1)
                        begin
                            // single cell goes to the larger direction, tie to transmit
                            q_reg    <= res.rx_gt_tx ? 8'd0 : 8'd1;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            q_reg     <= '0;
                            state_reg <= SH_MUL;
                        end
                    end
                end
                SH_MUL:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_reg <= SH_DIV;
                    end
                end
                SH_DIV:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    q_reg   <= {q_reg[tlbh_pkg::HEIGHT_W-2:0], num_ge};
                    if (cnt_reg == 3'd7)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= SH_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= SH_IDLE;
                end
            endcase
        end
    end

    // product and divisor registers
    always_ff @(posedge clk)
    begin
        if (state_reg == SH_IDLE && start)
        begin
            num_reg    <= '0;
            bar_sh_reg <= res.bar;
            den_reg    <= tlbh_pkg::PROD_W'(res.total) << (tlbh_pkg::HEIGHT_W - 1);
        end
        else if (state_reg == SH_MUL)
        begin
            num_reg    <= (num_reg << 1) + addend;
            bar_sh_reg <= bar_sh_reg << 1;
        end
        else if (state_reg == SH_DIV)
        begin
            if (num_ge)
            begin
                num_reg <= diff[tlbh_pkg::PROD_W-1:0];
            end
            den_reg <= den_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign tx_share = q_reg;

endmodule

`default_nettype wire

FILE: rtl/tlbh_hist.sv
// tlbh_hist: history column memory, one write and one registered read port
`default_nettype none

module tlbh_hist #(
    parameter int AW = 7
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire tlbh_pkg::hist_word_t wr_data,
    input  wire logic [AW-1:0]        rd_addr,
    output tlbh_pkg::hist_word_t      rd_data
);

    localparam int DEPTH = 1 << AW;

    tlbh_pkg::hist_word_t mem [DEPTH];
    tlbh_pkg::hist_word_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
